// ===== src/qrs_pkg.sv =====
`timescale 1ns / 1ps

package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int RAD_W     = PROD_W + 2;
  localparam int SQ_W      = RAD_W / 2;
  localparam int SQ_REM_W  = SQ_W + 2;
  localparam int NUM_W     = SQ_W + 1;
  localparam int DEN_W     = WORD_BITS + 1;
  localparam int QUO_W     = WORD_BITS;
  localparam int DVD_W     = NUM_W + FRAC_BITS;
  localparam int HI_W      = DVD_W - QUO_W;
  localparam int CMP_W     = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int LATENCY   = SQ_W + QUO_W + 3;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] coef_a;
    logic signed [WORD_BITS-1:0] coef_b;
    logic signed [WORD_BITS-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic                        has_roots;
    logic                        degenerate;
    logic                        overflow;
    logic signed [WORD_BITS-1:0] root_minus;
    logic signed [WORD_BITS-1:0] root_plus;
  } result_t;

  typedef struct packed {
    logic                        valid;
    logic                        degenerate;
    logic                        no_roots;
    logic                        a_neg;
    logic signed [WORD_BITS-1:0] coef_b;
    logic [DEN_W-1:0]            den;
  } tag_t;

  typedef struct packed {
    tag_t                tag;
    logic [RAD_W-1:0]    rad;
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_W-1:0]     root;
  } sq_t;

  typedef struct packed {
    logic             neg;
    logic             pre_ovf;
    logic [QUO_W-1:0] lo;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic             degenerate;
    logic             no_roots;
    logic [DEN_W-1:0] den;
    lane_t            mn;
    lane_t            pl;
  } dv_t;

endpackage

// ===== src/qrs_front.sv =====
`timescale 1ns / 1ps

module qrs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  qrs_pkg::coef_t    coef,
  output qrs_pkg::sq_t      sq
);

  localparam int W      = qrs_pkg::WORD_BITS;
  localparam int PROD_W = qrs_pkg::PROD_W;
  localparam int RAD_W  = qrs_pkg::RAD_W;
  localparam int DEN_W  = qrs_pkg::DEN_W;

  logic [W-1:0] ma, mb, mc;

  logic                v1;
  logic [PROD_W-1:0]   pbb;
  logic [PROD_W-1:0]   pac;
  logic                sgn_diff;
  logic                a_zero;
  logic                a_neg;
  logic signed [W-1:0] coef_b;
  logic [DEN_W-1:0]    den;

  logic [RAD_W-1:0] pbb_x, q4, disc;
  logic             no_roots;

  assign ma = coef.coef_a[W-1] ? W'(-coef.coef_a) : W'(coef.coef_a);
  assign mb = coef.coef_b[W-1] ? W'(-coef.coef_b) : W'(coef.coef_b);
  assign mc = coef.coef_c[W-1] ? W'(-coef.coef_c) : W'(coef.coef_c);

  always_ff @(posedge clk) begin
    pbb      <= PROD_W'(mb) * PROD_W'(mb);
    pac      <= PROD_W'(ma) * PROD_W'(mc);
    sgn_diff <= coef.coef_a[W-1] ^ coef.coef_c[W-1];
    a_zero   <= (coef.coef_a == '0);
    a_neg    <= coef.coef_a[W-1];
    coef_b   <= coef.coef_b;
    den      <= {ma, 1'b0};
    v1       <= valid;
    if (rst) begin
      v1 <= 1'b0;
    end
  end

  always_comb begin
    pbb_x    = RAD_W'(pbb);
    q4       = {pac, 2'b00};
    no_roots = 1'b0;
    disc     = '0;
    if (sgn_diff) begin
      disc = pbb_x + q4;
    end else if (q4 > pbb_x) begin
      no_roots = 1'b1;
    end else begin
      disc = pbb_x - q4;
    end
  end

  always_ff @(posedge clk) begin
    sq.tag.valid      <= v1;
    sq.tag.degenerate <= a_zero;
    sq.tag.no_roots   <= no_roots;
    sq.tag.a_neg      <= a_neg;
    sq.tag.coef_b     <= coef_b;
    sq.tag.den        <= den;
    sq.rad            <= disc;
    sq.rem            <= '0;
    sq.root           <= '0;
    if (rst) begin
      sq.tag.valid <= 1'b0;
    end
  end

endmodule

// ===== src/qrs_sqrt_step.sv =====
`timescale 1ns / 1ps

module qrs_sqrt_step (
  input  logic         clk,
  input  logic         rst,
  input  qrs_pkg::sq_t cur,
  output qrs_pkg::sq_t nxt
);

  localparam int RAD_W    = qrs_pkg::RAD_W;
  localparam int SQ_W     = qrs_pkg::SQ_W;
  localparam int SQ_REM_W = qrs_pkg::SQ_REM_W;

  logic [SQ_REM_W-1:0] rem2, trial;
  logic                take;

  assign rem2  = {cur.rem[SQ_REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
  assign trial = {cur.root, 2'b01};
  assign take  = (rem2 >= trial);

  always_ff @(posedge clk) begin
    nxt.tag  <= cur.tag;
    nxt.rad  <= {cur.rad[RAD_W-3:0], 2'b00};
    nxt.rem  <= take ? (rem2 - trial) : rem2;
    nxt.root <= {cur.root[SQ_W-2:0], take};
    if (rst) begin
      nxt.tag.valid <= 1'b0;
    end
  end

endmodule

// ===== src/qrs_div_step.sv =====
`timescale 1ns / 1ps

module qrs_div_step (
  input  logic         clk,
  input  logic         rst,
  input  qrs_pkg::dv_t cur,
  output qrs_pkg::dv_t nxt
);

  localparam int DEN_W = qrs_pkg::DEN_W;
  localparam int QUO_W = qrs_pkg::QUO_W;

  function automatic qrs_pkg::lane_t lane_step(qrs_pkg::lane_t l, logic [DEN_W-1:0] den);
    logic [DEN_W:0] r2;
    logic           take;
    qrs_pkg::lane_t o;
    r2     = {l.rem, l.lo[QUO_W-1]};
    take   = (r2 >= {1'b0, den});
    o      = l;
    o.lo   = {l.lo[QUO_W-2:0], 1'b0};
    o.rem  = take ? DEN_W'(r2 - {1'b0, den}) : r2[DEN_W-1:0];
    o.quo  = {l.quo[QUO_W-2:0], take};
    return o;
  endfunction

  always_ff @(posedge clk) begin
    nxt.valid      <= cur.valid;
    nxt.degenerate <= cur.degenerate;
    nxt.no_roots   <= cur.no_roots;
    nxt.den        <= cur.den;
    nxt.mn         <= lane_step(cur.mn, cur.den);
    nxt.pl         <= lane_step(cur.pl, cur.den);
    if (rst) begin
      nxt.valid <= 1'b0;
    end
  end

endmodule

// ===== src/quadratic_root_solver_core.sv =====
`timescale 1ns / 1ps

// Real roots of a*x^2 + b*x + c = 0 for signed Q16.16 coefficients.
// A transaction is accepted on a rising edge where start is high and busy is
// low; coef carries a, b and c. Busy is high only while rst is asserted, so a
// new coefficient set can enter on every clock cycle.
// The result appears on result for exactly one cycle, marked by result_valid.
// The products are registered at the accepting edge itself, then the
// discriminant is registered, the square-root stages follow (one result bit
// per stage), the numerators are registered, the division stages run the
// two dividers side by side (one quotient bit per stage), and the output
// register takes the saturated result. Throughput is one transaction per cycle.
// The receiver cannot stall the block; results are never held back.
// A synchronous reset clears every valid bit in the pipeline, so no result
// comes out of work that was in flight at reset.
module quadratic_root_solver_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  qrs_pkg::coef_t    coef,
  output logic              result_valid,
  output qrs_pkg::result_t  result
);

  localparam int W      = qrs_pkg::WORD_BITS;
  localparam int F      = qrs_pkg::FRAC_BITS;
  localparam int SQ_W   = qrs_pkg::SQ_W;
  localparam int NUM_W  = qrs_pkg::NUM_W;
  localparam int DEN_W  = qrs_pkg::DEN_W;
  localparam int QUO_W  = qrs_pkg::QUO_W;
  localparam int DVD_W  = qrs_pkg::DVD_W;
  localparam int HI_W   = qrs_pkg::HI_W;
  localparam int CMP_W  = qrs_pkg::CMP_W;

  function automatic qrs_pkg::lane_t lane_init(logic [NUM_W-1:0] mag, logic neg,
                                               logic [DEN_W-1:0] den);
    logic [DVD_W-1:0] dvd;
    logic [HI_W-1:0]  hi;
    logic [CMP_W-1:0] hx;
    qrs_pkg::lane_t   l;
    dvd       = {mag, {F{1'b0}}};
    hi        = dvd[DVD_W-1:QUO_W];
    hx        = CMP_W'(hi);
    l.neg     = neg;
    l.pre_ovf = (hx >= CMP_W'(den));
    l.rem     = hx[DEN_W-1:0];
    l.lo      = dvd[QUO_W-1:0];
    l.quo     = '0;
    return l;
  endfunction

  function automatic logic [W:0] lane_final(qrs_pkg::lane_t l);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] val;
    logic             ovf;
    lim = {1'b0, {(QUO_W-1){1'b1}}} + QUO_W'(l.neg);
    ovf = l.pre_ovf | (l.quo > lim);
    val = ovf ? lim : l.quo;
    return {ovf, (l.neg ? W'(-val) : W'(val))};
  endfunction

  qrs_pkg::sq_t sq_pipe [SQ_W+1];
  qrs_pkg::dv_t dv_pipe [QUO_W+1];

  logic                  accept;
  logic signed [NUM_W:0] nb, nm, np, sx;
  logic [NUM_W-1:0]      mag_m, mag_p;
  logic [W:0]            fin_m, fin_p;
  qrs_pkg::result_t      res_next;

  assign busy   = rst;
  assign accept = start & ~busy;

  qrs_front u_front (
    .clk   (clk),
    .rst   (rst),
    .valid (accept),
    .coef  (coef),
    .sq    (sq_pipe[0])
  );

  for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
    qrs_sqrt_step u_step (
      .clk (clk),
      .rst (rst),
      .cur (sq_pipe[i]),
      .nxt (sq_pipe[i+1])
    );
  end

  always_comb begin
    nb    = -((NUM_W+1)'(sq_pipe[SQ_W].tag.coef_b));
    sx    = $signed((NUM_W+1)'(sq_pipe[SQ_W].root));
    nm    = nb - sx;
    np    = nb + sx;
    mag_m = nm[NUM_W] ? NUM_W'(-nm) : NUM_W'(nm);
    mag_p = np[NUM_W] ? NUM_W'(-np) : NUM_W'(np);
  end

  always_ff @(posedge clk) begin
    dv_pipe[0].valid      <= sq_pipe[SQ_W].tag.valid;
    dv_pipe[0].degenerate <= sq_pipe[SQ_W].tag.degenerate;
    dv_pipe[0].no_roots   <= sq_pipe[SQ_W].tag.no_roots;
    dv_pipe[0].den        <= sq_pipe[SQ_W].tag.den;
    dv_pipe[0].mn         <= lane_init(mag_m, nm[NUM_W] ^ sq_pipe[SQ_W].tag.a_neg,
                                       sq_pipe[SQ_W].tag.den);
    dv_pipe[0].pl         <= lane_init(mag_p, np[NUM_W] ^ sq_pipe[SQ_W].tag.a_neg,
                                       sq_pipe[SQ_W].tag.den);
    if (rst) begin
      dv_pipe[0].valid <= 1'b0;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    qrs_div_step u_step (
      .clk (clk),
      .rst (rst),
      .cur (dv_pipe[j]),
      .nxt (dv_pipe[j+1])
    );
  end

  always_comb begin
    fin_m    = lane_final(dv_pipe[QUO_W].mn);
    fin_p    = lane_final(dv_pipe[QUO_W].pl);
    res_next = '0;
    if (dv_pipe[QUO_W].degenerate) begin
      res_next.degenerate = 1'b1;
    end else if (!dv_pipe[QUO_W].no_roots) begin
      res_next.has_roots  = 1'b1;
      res_next.overflow   = fin_m[W] | fin_p[W];
      res_next.root_minus = fin_m[W-1:0];
      res_next.root_plus  = fin_p[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result       <= res_next;
    result_valid <= dv_pipe[QUO_W].valid;
    if (rst) begin
      result_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept, qrs_pkg::LATENCY + 1))
    else $error("result strobe does not match an accepted transaction");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |->
      !result.has_roots && !result.overflow &&
      result.root_minus == '0 && result.root_plus == '0)
    else $error("degenerate result carries roots or flags");

  a_no_roots_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_roots |->
      !result.overflow && result.root_minus == '0 && result.root_plus == '0)
    else $error("result without roots carries values");
`endif

endmodule

// ===== test/quadratic_root_solver_core_test.sv =====
`timescale 1ns / 1ps

module quadratic_root_solver_core_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int W = qrs_pkg::WORD_BITS;
  localparam int F = qrs_pkg::FRAC_BITS;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  qrs_pkg::coef_t   coef;
  logic             result_valid;
  qrs_pkg::result_t result;

  qrs_pkg::result_t expected_roots[$];
  int      error_count;
  int      sent_count;
  int      checked_count;
  int      idle_cycles;
  int      real_count;
  int      degenerate_count;
  int      overflow_count;
  bit      gaps_on;
  bit      timed_out;

  quadratic_root_solver_core DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .coef(coef),
    .result_valid(result_valid),
    .result(result)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Floor square root of an unsigned value of up to 66 bits.
  function automatic logic [32:0] floor_sqrt(input logic [65:0] d);
    logic [32:0]  root;
    logic [32:0]  cand;
    logic [131:0] sq;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      cand = root | (33'd1 << i);
      sq = 132'(cand) * 132'(cand);
      if (sq <= 132'(d)) root = cand;
    end
    return root;
  endfunction

  // (num << FRAC_BITS) / (2a), truncated toward zero, then saturated.
  function automatic logic signed [W-1:0] scaled_quotient(
      input logic signed [67:0] num, input logic signed [W-1:0] a,
      inout bit ovf);
    bit           neg;
    logic [67:0]  nm;
    logic [67:0]  den;
    logic [95:0]  q;
    logic [95:0]  lim;
    neg = (num < 0) != (a < 0);
    nm  = num < 0 ? -num : num;
    den = 68'(a < 0 ? -68'(a) : 68'(a)) << 1;
    q   = (96'(nm) << F) / 96'(den);
    lim = (96'd1 << (W - 1)) - (neg ? 96'd0 : 96'd1);
    if (q > lim) begin
      ovf = 1'b1;
      q = lim;
    end
    return neg ? W'(-q) : W'(q);
  endfunction

  function automatic qrs_pkg::result_t predict_roots(input qrs_pkg::coef_t c);
    qrs_pkg::result_t   r;
    logic signed [67:0] disc;
    logic signed [67:0] s;
    bit                 ovf;
    r = '0;
    ovf = 1'b0;
    if (c.coef_a == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    disc = 68'(c.coef_b) * 68'(c.coef_b) - 68'sd4 * 68'(c.coef_a) * 68'(c.coef_c);
    if (disc < 0) return r;
    s = 68'(floor_sqrt(66'(disc)));
    r.has_roots  = 1'b1;
    r.root_minus = scaled_quotient(-68'(c.coef_b) - s, c.coef_a, ovf);
    r.root_plus  = scaled_quotient(-68'(c.coef_b) + s, c.coef_a, ovf);
    r.overflow   = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("Mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_coefficients(input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] c);
    if (gaps_on) begin
      while ($urandom_range(99) < 7) begin
        start <= 1'b0;
        coef  <= '{coef_a: $urandom, coef_b: $urandom, coef_c: $urandom};
        @(negedge clk);
      end
    end
    start <= 1'b1;
    coef  <= '{coef_a: a, coef_b: b, coef_c: c};
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_roots.push_back(predict_roots('{coef_a: a, coef_b: b, coef_c: c}));
    sent_count++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    qrs_pkg::result_t want;
    if (!rst && result_valid) begin
      if (expected_roots.size() == 0) begin
        $display("Unexpected result at %0t", $realtime);
        error_count++;
      end else begin
        want = expected_roots.pop_front();
        checked_count++;
        if (want.has_roots) real_count++;
        if (want.degenerate) degenerate_count++;
        if (want.overflow) overflow_count++;
        if (result.has_roots !== want.has_roots)
          report_mismatch("has_roots", result.has_roots, want.has_roots);
        if (result.degenerate !== want.degenerate)
          report_mismatch("degenerate", result.degenerate, want.degenerate);
        if (result.overflow !== want.overflow)
          report_mismatch("overflow", result.overflow, want.overflow);
        if (result.root_minus !== want.root_minus)
          report_mismatch("root_minus", result.root_minus, want.root_minus);
        if (result.root_plus !== want.root_plus)
          report_mismatch("root_plus", result.root_plus, want.root_plus);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Watchdog expired at %0t", $realtime);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed_extremes();
    logic [31:0] one;
    one = 32'h0001_0000;
    send_coefficients(one, 32'h0003_0000, 32'h0002_0000);
    send_coefficients(one, 32'd0, one);
    send_coefficients(32'd0, 32'h1234_5678, 32'h8765_4321);
    send_coefficients(32'd0, 32'd0, 32'd0);
    send_coefficients(one, 32'h0002_0000, one);
    send_coefficients(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefficients(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_coefficients(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_coefficients(32'h0000_0001, 32'h8000_0000, 32'd0);
    send_coefficients(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coefficients(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_coefficients(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_coefficients(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_coefficients(32'hFFFF_0000, 32'h0004_0000, 32'h0005_0000);
    send_coefficients(32'h0000_0001, 32'd0, 32'h8000_0000);
    send_coefficients(32'h0000_0002, 32'h0000_0001, 32'd0);
  endtask

  task automatic test_random_small_roots();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    for (int i = 0; i < 400; i++) begin
      gaps_on = !(i >= 150 && i < 250);
      a = 32'($signed($urandom_range(65536 * 64)) - 65536 * 32);
      if ($urandom_range(19) == 0) a = 0;
      b = 32'($signed($urandom_range(65536 * 512)) - 65536 * 256);
      c = 32'($signed($urandom_range(65536 * 512)) - 65536 * 256);
      send_coefficients(a, b, c);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_full_range();
    logic [31:0] a;
    for (int i = 0; i < 400; i++) begin
      a = $urandom;
      if ($urandom_range(3) == 0) a = 32'($signed($urandom_range(255)) - 128);
      send_coefficients(a, $urandom, $urandom);
    end
  endtask

  initial begin
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    idle_cycles = 0;
    real_count = 0;
    degenerate_count = 0;
    overflow_count = 0;
    timed_out = 1'b0;
    gaps_on = 1'b1;
    rst = 1'b1;
    start = 1'b0;
    coef = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_extremes();
    test_random_small_roots();
    test_random_full_range();
    start <= 1'b0;
    coef  <= '{coef_a: $urandom, coef_b: $urandom, coef_c: $urandom};
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (qrs_pkg::LATENCY + 10) @(posedge clk);
    $display("Sent %0d coefficient sets and checked %0d results.", sent_count, checked_count);
    $display("Real roots %0d, degenerate %0d, saturated %0d.",
             real_count, degenerate_count, overflow_count);
    if (error_count == 0 && expected_roots.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/qrs_pkg.sv
src/qrs_front.sv
src/qrs_sqrt_step.sv
src/qrs_div_step.sv
src/quadratic_root_solver_core.sv
test/quadratic_root_solver_core_test.sv
